[sv/srwt_pkg.sv]
// Package with the constants, codes and item types of the SACK receive window tracker.
package srwt_pkg;

    localparam int SLOT_W      = 5;
    localparam int SLOT_COUNT  = 1 << SLOT_W;
    localparam int MAX_RANGES  = 3;
    localparam int CNT_W       = $clog2(MAX_RANGES + 1);
    localparam int RIDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int OFS_W       = 5;
    localparam int SEQ_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [OFS_W-1:0]     WINDOW_RESET = 5'd20;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b1;

    localparam logic [1:0] CMD_MARK    = 2'd0;
    localparam logic [1:0] CMD_CONSUME = 2'd1;
    localparam logic [1:0] CMD_REPORT  = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CONS,
        S_REP,
        S_BASE_RD,
        S_BASE_EV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [SEQ_W-1:0] frag_sequence;
        logic                    payload_ok;
        logic [OFS_W-1:0]        consume_limit;
    } in_item_t;

    typedef struct packed {
        logic [30:0]      base_sequence;
        logic             marked;
        logic [OFS_W-1:0] consumed_count;
        logic             data_ready;
        logic             range_valid;
        logic [OFS_W-1:0] range_start;
        logic [OFS_W-1:0] range_length;
        logic             last;
    } out_item_t;

endpackage

[sv/sack_receive_window_tracker.sv]
// Top level of the SACK receive window tracker: slot tag memory, probe sequencer and result stage.
//
// Usage: one item enters on in_valid/in_ready and carries a command: mark a received
// fragment, consume the contiguous run at the read base, or build an acknowledge report.
// Each item gives one result on out_valid/out_ready, or one result per selective range
// for a report that finds ranges; the final result of an item has last set.
// The block works on one item at a time; in_ready is high only while it is idle.
// A mark, a disabled channel or an unused command passes from acceptance through the start,
// base read and base evaluation states to the result; a consume first probes up to
// receive_window slots and a report up to receive_window minus the resume offset, one
// slot per cycle through the single read port of the tag memory.
// Slot tags live in a synchronous memory; a valid bit per slot, cleared at reset and on
// any write of channel_enable, stands for the all-ones reset tag, so there is no
// clearing pass. The user must write the configuration port only while the block is
// idle; the block itself does not enforce it.
// When the receiver stalls, the result holds on out_item and no new item is taken.
module sack_receive_window_tracker
    import srwt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Control and configuration state.
    state_t            state_reg, state_next;
    logic [SEQ_W-1:0]  read_base_reg, read_base_next;
    logic [OFS_W-1:0]  scan_resume_reg, scan_resume_next;
    logic [OFS_W-1:0]  window_reg;
    logic              enable_reg;
    logic [SLOT_COUNT-1:0] slot_vld_reg;

    // Item registers.
    logic [1:0]        cmd_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic              ok_reg;
    logic [OFS_W-1:0]  limit_reg;

    // Scan and result registers.
    logic              marked_reg, marked_next;
    logic [OFS_W-1:0]  consumed_reg, consumed_next;
    logic [OFS_W-1:0]  idx_reg, idx_next;
    logic              in_run_reg, in_run_next;
    logic [OFS_W-1:0]  cur_start_reg, cur_start_next;
    logic [OFS_W-1:0]  cur_len_reg, cur_len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  out_k_reg, out_k_next;
    logic              data_ready_reg, data_ready_next;
    logic [OFS_W-1:0]  start_arr [MAX_RANGES];
    logic [OFS_W-1:0]  len_arr [MAX_RANGES];
    logic              rec_we;
    logic [OFS_W-1:0]  rec_start, rec_len;

    // Tag memory and its read side.
    logic [SEQ_W-1:0]  tag_mem [SLOT_COUNT];
    logic [SEQ_W-1:0]  rd_data_reg;
    logic              rd_vld_reg;
    logic [SEQ_W-1:0]  probe_reg;
    logic [OFS_W-1:0]  rd_off;
    logic [SEQ_W-1:0]  probe_seq;
    logic              mem_we;
    logic              slot_hit;

    // Decoded conditions.
    logic              is_active;
    logic              is_report;
    logic              enable_wr;
    logic              in_win;
    logic [OFS_W-1:0]  cons_run;
    logic              cons_more;
    logic [OFS_W-1:0]  taken;
    logic [OFS_W-1:0]  rep_i_n;
    logic              rep_end;
    logic              rep_full;
    logic              rep_close;
    logic              rep_run_after;
    logic [OFS_W-1:0]  rep_start_after;
    logic [OFS_W-1:0]  rep_len_after;
    logic              rep_done;
    logic [CNT_W-1:0]  cnt_inc;
    logic              res_last;

    assign is_active = enable_reg && (cmd_reg != CMD_NONE);
    assign is_report = enable_reg && (cmd_reg == CMD_REPORT);
    assign enable_wr = cfg_write && (cfg_index == REG_ENABLE);

    assign probe_seq = read_base_reg + {{(SEQ_W-OFS_W){1'b0}}, rd_off};
    assign slot_hit  = rd_vld_reg && (rd_data_reg == probe_reg);

    // A mark is tagged when the payload is good and the sequence is not negative and lies inside the window.
    assign in_win = !seq_reg[SEQ_W-1] && ok_reg
                    && ({1'b0, seq_reg} >= {1'b0, read_base_reg})
                    && ({1'b0, seq_reg} < ({1'b0, read_base_reg}
                        + {{(SEQ_W+1-OFS_W){1'b0}}, window_reg}));

    assign cons_run  = slot_hit ? (idx_reg + OFS_W'(1)) : idx_reg;
    assign cons_more = slot_hit && (cons_run < window_reg);
    assign taken     = (cons_run < limit_reg) ? cons_run : limit_reg;

    // One report scan step at offset idx_reg.
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign rep_close = !slot_hit && in_run_reg;
    assign rep_full  = rep_close && (cnt_inc == CNT_W'(MAX_RANGES));
    assign rep_i_n   = idx_reg + OFS_W'(1);
    assign rep_end   = !rep_full && !(rep_i_n < window_reg);
    assign rep_done  = rep_full || rep_end;
    assign rep_run_after   = slot_hit;
    assign rep_start_after = (slot_hit && !in_run_reg) ? idx_reg : cur_start_reg;
    assign rep_len_after   = slot_hit ? (in_run_reg ? (cur_len_reg + OFS_W'(1)) : OFS_W'(1))
                                      : cur_len_reg;

    assign res_last = !(is_report && (cnt_reg != '0)) || (out_k_reg + CNT_W'(1) == cnt_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_START;
            end
            S_START:
            begin
                priority if (!is_active || cmd_reg == CMD_MARK)
                    state_next = S_BASE_RD;
                else if (cmd_reg == CMD_CONSUME)
                    state_next = (window_reg == '0) ? S_BASE_RD : S_CONS;
                else
                    state_next = (scan_resume_reg < window_reg) ? S_REP : S_BASE_RD;
            end
            S_CONS:
            begin
                if (!cons_more)
                    state_next = S_BASE_RD;
            end
            S_REP:
            begin
                if (rep_done)
                    state_next = S_BASE_RD;
            end
            S_BASE_RD: state_next = S_BASE_EV;
            S_BASE_EV: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready && res_last)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Handshake and memory controls.
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        mem_we    = 1'b0;
        rd_off    = '0;
        unique case (state_reg)
            S_IDLE:    in_ready = 1'b1;
            S_START:
            begin
                if (is_active && cmd_reg == CMD_MARK)
                    mem_we = in_win;
                if (is_active && cmd_reg == CMD_REPORT)
                    rd_off = scan_resume_reg;
            end
            S_CONS:    rd_off = cons_run;
            S_REP:     rd_off = rep_i_n;
            S_BASE_RD: rd_off = '0;
            S_BASE_EV: rd_off = '0;
            S_OUT:     out_valid = 1'b1;
            default:   rd_off = '0;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        read_base_next   = read_base_reg;
        scan_resume_next = scan_resume_reg;
        marked_next      = marked_reg;
        consumed_next    = consumed_reg;
        idx_next         = idx_reg;
        in_run_next      = in_run_reg;
        cur_start_next   = cur_start_reg;
        cur_len_next     = cur_len_reg;
        cnt_next         = cnt_reg;
        out_k_next       = out_k_reg;
        data_ready_next  = data_ready_reg;
        rec_we           = 1'b0;
        rec_start        = rep_start_after;
        rec_len          = rep_len_after;
        unique case (state_reg)
            S_START:
            begin
                marked_next   = is_active && (cmd_reg == CMD_MARK) && in_win;
                consumed_next = '0;
                cnt_next      = '0;
                in_run_next   = 1'b0;
                idx_next      = (cmd_reg == CMD_REPORT) ? scan_resume_reg : '0;
                if (is_report && !(scan_resume_reg < window_reg))
                    scan_resume_next = OFS_W'(1);
            end
            S_CONS:
            begin
                if (cons_more)
                    idx_next = cons_run;
                else
                begin
                    consumed_next  = taken;
                    read_base_next = read_base_reg + {{(SEQ_W-OFS_W){1'b0}}, taken};
                    if (taken > OFS_W'(1))
                        scan_resume_next = OFS_W'(1);
                end
            end
            S_REP:
            begin
                in_run_next    = rep_run_after;
                cur_start_next = rep_start_after;
                cur_len_next   = rep_len_after;
                // A gap closes the open range; reaching the window end closes it too.
                if (rep_close)
                begin
                    rec_we    = 1'b1;
                    rec_start = cur_start_reg;
                    rec_len   = cur_len_reg;
                    cnt_next  = cnt_inc;
                end
                else if (rep_end && rep_run_after)
                begin
                    rec_we   = 1'b1;
                    cnt_next = cnt_inc;
                end
                if (rep_full)
                    scan_resume_next = idx_reg;
                else if (rep_end)
                    scan_resume_next = OFS_W'(1);
                else
                    idx_next = rep_i_n;
            end
            S_BASE_EV:
            begin
                data_ready_next = slot_hit;
                out_k_next      = '0;
            end
            S_OUT:
            begin
                if (out_ready)
                    out_k_next = out_k_reg + CNT_W'(1);
            end
            default:
            begin
                rec_we = 1'b0;
            end
        endcase
        // Any write of the enable returns the window state to reset.
        if (enable_wr)
        begin
            read_base_next   = '0;
            scan_resume_next = '0;
        end
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            read_base_reg   <= '0;
            scan_resume_reg <= '0;
            window_reg      <= WINDOW_RESET;
            enable_reg      <= 1'b0;
            slot_vld_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            out_k_reg       <= '0;
            cnt_reg         <= '0;
            in_run_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            read_base_reg   <= read_base_next;
            scan_resume_reg <= scan_resume_next;
            out_k_reg       <= out_k_next;
            cnt_reg         <= cnt_next;
            in_run_reg      <= in_run_next;
            rd_vld_reg      <= slot_vld_reg[probe_seq[SLOT_W-1:0]];
            if (enable_wr)
                slot_vld_reg <= '0;
            else if (mem_we)
                slot_vld_reg[seq_reg[SLOT_W-1:0]] <= 1'b1;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_WINDOW: window_reg <= cfg_data;
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    default:    window_reg <= window_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= in_item.cmd;
            seq_reg   <= in_item.frag_sequence;
            ok_reg    <= in_item.payload_ok;
            limit_reg <= in_item.consume_limit;
        end
        marked_reg     <= marked_next;
        consumed_reg   <= consumed_next;
        idx_reg        <= idx_next;
        cur_start_reg  <= cur_start_next;
        cur_len_reg    <= cur_len_next;
        data_ready_reg <= data_ready_next;
        if (rec_we)
        begin
            start_arr[cnt_reg[RIDX_W-1:0]] <= rec_start;
            len_arr[cnt_reg[RIDX_W-1:0]]   <= rec_len;
        end
    end

    // Tag memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tag_mem[seq_reg[SLOT_W-1:0]] <= seq_reg;
        rd_data_reg <= tag_mem[probe_seq[SLOT_W-1:0]];
        probe_reg   <= probe_seq;
    end

    // Result fields.
    always_comb
    begin
        out_item.base_sequence  = read_base_reg[30:0];
        out_item.data_ready     = data_ready_reg;
        out_item.last           = res_last;
        if (is_report && (cnt_reg != '0))
        begin
            out_item.marked         = 1'b0;
            out_item.consumed_count = '0;
            out_item.range_valid    = 1'b1;
            out_item.range_start    = start_arr[out_k_reg[RIDX_W-1:0]];
            out_item.range_length   = len_arr[out_k_reg[RIDX_W-1:0]];
        end
        else
        begin
            out_item.marked         = marked_reg;
            out_item.consumed_count = consumed_reg;
            out_item.range_valid    = 1'b0;
            out_item.range_start    = '0;
            out_item.range_length   = '0;
        end
    end

endmodule

[sv/srwt_checker.sv]
// Port-level checker for the SACK receive window tracker, with its bind statement.
module srwt_checker
    import srwt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_ready,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_item
);

    // The block holds one item at a time, so it never takes an item while a result waits.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // A result without last is followed at once by the next range of the same item.
    a_next_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last |=> out_valid)
        else $error("missing follow-on range result");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_item.last |=> in_ready && !out_valid)
        else $error("block not idle after the final result");

    // Range results carry no mark or consume information and never an empty range.
    a_range_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.range_valid |->
            !out_item.marked && (out_item.consumed_count == '0)
            && (out_item.range_length != '0))
        else $error("malformed range result");

endmodule

bind sack_receive_window_tracker srwt_checker u_srwt_checker (.*);

[sim/sack_receive_window_tracker_test.sv]
// Self-checking testbench for the SACK receive window tracker, with its own window predictor.
module sack_receive_window_tracker_test
    import srwt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SHOWN_LIMIT   = 10;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         PHASES        = 7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted window state and configuration.
    logic [31:0]      win_base;
    logic [31:0]      tag_mem [SLOT_COUNT];
    logic [OFS_W-1:0] scan_pos;
    logic [OFS_W-1:0] win_size;
    logic             chan_on;

    in_item_t  pending_items [$];
    out_item_t expected_acks [$];
    out_item_t want_ack;
    int        mismatches = 0;
    int        stall_cycles = 0;
    bit        no_idle = 1'b0;

    sack_receive_window_tracker uut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .in_item,
        .out_valid,
        .out_ready,
        .out_item,
        .cfg_write,
        .cfg_index,
        .cfg_data
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_window();
        win_base = '0;
        foreach (tag_mem[k])
            tag_mem[k] = '1;
        scan_pos = '0;
    endfunction

    function automatic bit slot_holds(logic [32:0] seq);
        return {1'b0, tag_mem[seq[SLOT_W-1:0]]} == seq;
    endfunction

    function automatic out_item_t make_ack(bit marked, logic [OFS_W-1:0] taken, bit rv,
                                           logic [OFS_W-1:0] rs, logic [OFS_W-1:0] rl,
                                           bit fin);
        out_item_t r;
        r.base_sequence  = win_base[30:0];
        r.marked         = marked;
        r.consumed_count = taken;
        r.data_ready     = slot_holds({1'b0, win_base});
        r.range_valid    = rv;
        r.range_start    = rs;
        r.range_length   = rl;
        r.last           = fin;
        return r;
    endfunction

    function automatic string ack_text(out_item_t a);
        return {$sformatf("base %0d marked %0d taken %0d ready %0d ",
                          a.base_sequence, a.marked, a.consumed_count, a.data_ready),
                $sformatf("range %0d start %0d len %0d last %0d",
                          a.range_valid, a.range_start, a.range_length, a.last)};
    endfunction

    // Applies one accepted item to the predicted window and queues the results it causes.
    function automatic void predict_acks(in_item_t it);
        logic [32:0]      b;
        logic [32:0]      s;
        int               run;
        int               taken;
        int               i;
        int               cnt;
        int               rlen;
        bit               in_run;
        bit               marked;
        logic [OFS_W-1:0] starts [MAX_RANGES];
        logic [OFS_W-1:0] lens [MAX_RANGES];

        b = {1'b0, win_base};
        if (!chan_on || it.cmd == CMD_NONE)
        begin
            expected_acks.push_back(make_ack(1'b0, '0, 1'b0, '0, '0, 1'b1));
        end
        else if (it.cmd == CMD_MARK)
        begin
            marked = 1'b0;
            if (!it.frag_sequence[31] && it.payload_ok)
            begin
                s = {1'b0, it.frag_sequence};
                if (s >= b && s < b + 33'(win_size))
                begin
                    tag_mem[s[SLOT_W-1:0]] = it.frag_sequence;
                    marked = 1'b1;
                end
            end
            expected_acks.push_back(make_ack(marked, '0, 1'b0, '0, '0, 1'b1));
        end
        else if (it.cmd == CMD_CONSUME)
        begin
            run = 0;
            while (run < int'(win_size) && slot_holds(b + 33'(run)))
                run++;
            taken = (run < int'(it.consume_limit)) ? run : int'(it.consume_limit);
            win_base = 32'(b + 33'(taken));
            if (taken > 1)
                scan_pos = 5'd1;
            expected_acks.push_back(make_ack(1'b0, 5'(taken), 1'b0, '0, '0, 1'b1));
        end
        else
        begin
            cnt = 0;
            rlen = 0;
            in_run = 1'b0;
            for (i = int'(scan_pos); i < int'(win_size); i++)
            begin
                if (slot_holds(b + 33'(i)))
                begin
                    if (!in_run)
                    begin
                        starts[cnt] = 5'(i);
                        rlen = 0;
                    end
                    in_run = 1'b1;
                    rlen++;
                end
                else if (in_run)
                begin
                    lens[cnt] = 5'(rlen);
                    cnt++;
                    in_run = 1'b0;
                    if (cnt >= MAX_RANGES)
                        break;
                end
            end
            if (in_run)
            begin
                lens[cnt] = 5'(rlen);
                cnt++;
            end
            // A scan that ran to the window end restarts at offset 1 next time.
            scan_pos = (i < int'(win_size)) ? 5'(i) : 5'd1;
            if (cnt == 0)
                expected_acks.push_back(make_ack(1'b0, '0, 1'b0, '0, '0, 1'b1));
            for (int k = 0; k < cnt; k++)
                expected_acks.push_back(make_ack(1'b0, '0, 1'b1, starts[k], lens[k],
                                                 k + 1 == cnt));
        end
    endfunction

    // Item driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_acks(in_item);
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 33))
                begin
                    in_valid <= 1'b1;
                    in_item <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_acks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_LIMIT)
                        $display("unexpected result: %s", ack_text(out_item));
                end
                else
                begin
                    want_ack = expected_acks.pop_front();
                    if (want_ack.base_sequence !== out_item.base_sequence
                        || want_ack.marked !== out_item.marked
                        || want_ack.consumed_count !== out_item.consumed_count
                        || want_ack.data_ready !== out_item.data_ready
                        || want_ack.range_valid !== out_item.range_valid
                        || want_ack.range_start !== out_item.range_start
                        || want_ack.range_length !== out_item.range_length
                        || want_ack.last !== out_item.last)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN_LIMIT)
                        begin
                            $display("result mismatch, expected: %s", ack_text(want_ack));
                            $display("                   actual: %s", ack_text(out_item));
                        end
                    end
                end
            end
            out_ready <= no_idle || $urandom_range(99) >= 33;
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL sack_receive_window_tracker");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic wait_for_room();
        while (pending_items.size() > 1)
            @(negedge clk);
    endtask

    task automatic queue_fixed(logic [1:0] cmd, logic signed [31:0] seq, logic ok,
                               logic [OFS_W-1:0] lim);
        in_item_t it;
        wait_for_room();
        it.cmd = cmd;
        it.frag_sequence = seq;
        it.payload_ok = ok;
        it.consume_limit = lim;
        pending_items.push_back(it);
    endtask

    // Half the items are marks, mostly near the current base, so that runs and ranges build up.
    task automatic queue_random();
        in_item_t it;
        int       roll;
        wait_for_room();
        roll = $urandom_range(99);
        it.frag_sequence = $urandom;
        it.payload_ok = $urandom_range(1);
        if ($urandom_range(1))
            it.consume_limit = 5'($urandom_range(3));
        else
            it.consume_limit = 5'($urandom_range(31));
        if (roll < 50)
        begin
            it.cmd = CMD_MARK;
            it.payload_ok = $urandom_range(9) != 0;
            case ($urandom_range(9))
                0: it.frag_sequence = -1;
                1: it.frag_sequence = {1'b0, 31'($urandom)};
                2: it.frag_sequence = win_base - 32'd1;
                3, 4, 5: it.frag_sequence = win_base + 32'($urandom_range(3));
                default: it.frag_sequence = win_base + 32'($urandom_range(int'(win_size) + 1));
            endcase
        end
        else if (roll < 72)
        begin
            it.cmd = CMD_CONSUME;
        end
        else if (roll < 94)
        begin
            it.cmd = CMD_REPORT;
        end
        else
        begin
            it.cmd = CMD_NONE;
        end
        pending_items.push_back(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_WINDOW)
        begin
            win_size = val;
        end
        else
        begin
            // Any write of the enable register also clears the window.
            chan_on = val[0];
            clear_window();
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_acks.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase_win [PHASES];
        int phase_len [PHASES];

        phase_win = '{20, 1, 31, 0, 8, 31, 20};
        phase_len = '{55, 35, 55, 15, 55, 60, 55};
        phase_win[6] = $urandom_range(2, 30);
        win_size = WINDOW_RESET;
        chan_on = 1'b0;
        clear_window();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // The channel is still disabled after reset, so these change nothing.
        repeat (4) queue_random();
        settle();

        write_reg(REG_ENABLE, 5'd1);
        queue_fixed(CMD_MARK, -32'sd1, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd0, 1'b0, 5'd31);
        queue_fixed(CMD_MARK, 32'sd0, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd1, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd3, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd19, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd20, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sh7fffffff, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd5, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd6, 1'b1, 5'd0);
        // Three ranges stop the scan early; the next report runs to the window end.
        queue_fixed(CMD_REPORT, 32'sd0, 1'b0, 5'd0);
        queue_fixed(CMD_REPORT, -32'sd1, 1'b1, 5'd31);
        queue_fixed(CMD_NONE, -32'sd1, 1'b1, 5'd31);
        queue_fixed(CMD_CONSUME, 32'sd0, 1'b0, 5'd0);
        queue_fixed(CMD_CONSUME, 32'sd0, 1'b0, 5'd1);
        queue_fixed(CMD_REPORT, 32'sd0, 1'b0, 5'd0);
        queue_fixed(CMD_CONSUME, 32'sd0, 1'b1, 5'd31);
        queue_fixed(CMD_MARK, 32'sd1, 1'b1, 5'd0);
        queue_fixed(CMD_MARK, 32'sd2, 1'b1, 5'd0);
        queue_fixed(CMD_CONSUME, 32'sd0, 1'b1, 5'd31);
        queue_fixed(CMD_REPORT, 32'sd0, 1'b0, 5'd0);
        queue_fixed(CMD_NONE, 32'sd0, 1'b0, 5'd0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_WINDOW, 5'(phase_win[p]));
            write_reg(REG_ENABLE, 5'd1);
            no_idle = (p == 0);
            repeat (phase_len[p]) queue_random();
            settle();
        end

        // Disable the channel mid-run, then bring it back for a short stretch.
        write_reg(REG_ENABLE, 5'd0);
        repeat (4) queue_random();
        settle();
        write_reg(REG_ENABLE, 5'd1);
        repeat (10) queue_random();
        settle();

        mismatches += expected_acks.size();
        if (mismatches == 0)
            $display("PASS sack_receive_window_tracker");
        else
            $display("FAIL sack_receive_window_tracker");
        $finish;
    end

endmodule
